@@ hw/rtl/head_angle_conditioner_assert.svh @@
// Assertion macros for the head angle conditioner RTL.
`ifndef HEAD_ANGLE_CONDITIONER_ASSERT_SVH
`define HEAD_ANGLE_CONDITIONER_ASSERT_SVH

// Property must hold on every clock edge outside reset.
`define HAC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property must hold also during reset.
`define HAC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ hw/rtl/hac_pkg.sv @@
// ----------------------------------------------------------------------------
// hac_pkg
// Types and constants shared by the head angle conditioner modules.
// ----------------------------------------------------------------------------
package hac_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_DRIFT  = 3'd0;
   localparam logic [2:0] REG_LINEAR = 3'd1;
   localparam logic [2:0] REG_GAIN_Y = 3'd2;
   localparam logic [2:0] REG_GAIN_R = 3'd3;
   localparam logic [2:0] REG_GAIN_P = 3'd4;
   localparam logic [2:0] REG_LEVEL  = 3'd5;

   localparam int unsigned STEP_WINDOW = 300;
   localparam int unsigned PITCH_WINDOW = 1000;
   localparam int unsigned DRIFT_SHIFT = 10;
   localparam int unsigned CURVE_SHIFT = 13;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CENTER,
      ST_DRIFT_MUL,
      ST_DRIFT_SUB,
      ST_AUTO,
      ST_CURVE,
      ST_GAIN,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       center;
      logic       drift_mul;
      logic       drift_sub;
      logic       auto_step;
      logic       curve;
      logic       gain;
      logic       emit;
      logic [1:0] axis;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ready;
   } status_type;

endpackage

@@ hw/rtl/hac_datapath.sv @@
// ----------------------------------------------------------------------------
// hac_datapath
// Angle registers, centering state, auto-centering and a shared multiplier.
// ----------------------------------------------------------------------------
module hac_datapath
   import hac_pkg::*;
#(
   parameter int CENTER_LOG2 = 3,
   parameter int STEADY_LOG2 = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [15:0] yaw_in,
   input  logic signed [15:0] roll_in,
   input  logic signed [15:0] pitch_in,
   input  logic               recenter_in,
   input  logic signed [15:0] drift,
   input  logic               linear,
   input  logic signed [15:0] gain_y,
   input  logic signed [15:0] gain_r,
   input  logic signed [15:0] gain_p,
   input  logic [6:0]         level,
   output logic               valid_out,
   output logic signed [15:0] yaw_out,
   output logic signed [15:0] roll_out,
   output logic signed [15:0] pitch_out
);

   localparam logic [31:0] CNT_START = 32'(0) - (32'(1) << CENTER_LOG2);
   localparam logic [12:0] STEADY_FULL = 13'(1) << STEADY_LOG2;

   // Persistent state.
   logic               pending_ff, pending_in;
   logic [31:0]        cnt_ff, cnt_in;
   logic signed [15:0] off_ff  [3];
   logic signed [15:0] off_in  [3];
   logic signed [15:0] bias_ff [3];
   logic signed [15:0] bias_in [3];
   logic               ready_ff, ready_in;
   logic [12:0]        ticks_ff, ticks_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [31:0] sum_ff, sum_in;
   logic signed [15:0] acoff_ff, acoff_in;

   // Working registers for one item.
   logic signed [15:0] e_ff [3];
   logic signed [15:0] e_in [3];
   logic               rec_ff, rec_in;
   logic signed [31:0] prod_ff, prod_in;
   logic               valid_ff, valid_in;
   logic signed [15:0] res_ff [3];
   logic signed [15:0] res_in [3];

   // Output registers that hold a finished item until it is read.
   logic               ovld_ff, ovld_in;
   logic signed [15:0] ores_ff [3];
   logic signed [15:0] ores_in [3];

   // Shared multiplier operands.
   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [49:0] mul_p;

   logic signed [16:0] e0w, abs_e0, abs_e2, dprev, abs_dprev, ax, lim17;
   logic signed [15:0] lim16, gsel, yaw_ac;
   logic signed [15:0] cur;
   logic               steady;

   always_comb begin
      cur = e_ff[cmd.axis];
      ax = (cur < 0) ? -17'(cur) : 17'(cur);
      unique case (cmd.axis)
         2'd0:    gsel = gain_y;
         2'd1:    gsel = gain_r;
         default: gsel = gain_p;
      endcase
      mul_a = 33'(signed'(cur));
      mul_b = ax;
      if (cmd.drift_mul) begin
         mul_a = 33'(signed'(cnt_ff));
         mul_b = 17'(drift);
      end else if (cmd.gain) begin
         mul_a = (linear) ? 33'(signed'(cur)) : 33'(signed'(prod_ff[15:0]));
         mul_b = 17'(gsel);
      end
      mul_p = mul_a * mul_b;
   end

   // Auto-centering window tests.
   always_comb begin
      lim16 = 16'(32'(level) * STEP_WINDOW);
      lim17 = 17'(lim16);
      yaw_ac = e_ff[0] + acoff_ff;
      e0w = 17'(yaw_ac);
      abs_e0 = (e0w < 0) ? -e0w : e0w;
      abs_e2 = (e_ff[2] < 0) ? -17'(e_ff[2]) : 17'(e_ff[2]);
      dprev = 17'(yaw_ac) - 17'(prev_ff);
      abs_dprev = (dprev < 0) ? -dprev : dprev;
      steady = (abs_e0 < lim17) && (abs_dprev < 17'(STEP_WINDOW))
               && (abs_e2 < 17'(PITCH_WINDOW));
   end

   always_comb begin
      logic [31:0] c1;
      logic signed [15:0] t;
      pending_in = pending_ff;
      cnt_in = cnt_ff;
      off_in = off_ff;
      bias_in = bias_ff;
      ready_in = ready_ff;
      ticks_in = ticks_ff;
      prev_in = prev_ff;
      sum_in = sum_ff;
      acoff_in = acoff_ff;
      e_in = e_ff;
      rec_in = rec_ff;
      prod_in = prod_ff;
      valid_in = valid_ff;
      res_in = res_ff;
      ovld_in = ovld_ff;
      ores_in = ores_ff;
      c1 = '0;
      t = '0;
      if (cmd.load) begin
         e_in[0] = yaw_in;
         e_in[1] = roll_in;
         e_in[2] = pitch_in;
         rec_in = recenter_in;
      end
      // Centering, counter and offset subtraction in one step.
      if (cmd.center) begin
         c1 = cnt_ff;
         if (pending_ff || rec_ff) begin
            c1 = CNT_START;
            ready_in = 1'b0;
            bias_in = e_ff;
            for (int i = 0; i < 3; i++) off_in[i] = '0;
         end
         c1 = c1 + 32'd1;
         cnt_in = c1;
         pending_in = 1'b0;
         if (!ready_in)
            for (int i = 0; i < 3; i++) off_in[i] = off_in[i] + e_ff[i] - bias_in[i];
         if (c1 == '0) begin
            for (int i = 0; i < 3; i++)
               off_in[i] = (off_in[i] >>> CENTER_LOG2) + bias_in[i];
            ready_in = 1'b1;
            if (level != '0) acoff_in = '0;
         end
         valid_in = ready_in;
         for (int i = 0; i < 3; i++) e_in[i] = e_ff[i] - off_in[i];
      end
      if (cmd.drift_mul) prod_in = mul_p[31:0];
      if (cmd.drift_sub) e_in[0] = e_ff[0] - 16'(prod_ff >>> DRIFT_SHIFT);
      if (cmd.auto_step && level != '0) begin
         e_in[0] = yaw_ac;
         prev_in = yaw_ac;
         if (steady) begin
            ticks_in = ticks_ff + 13'd1;
            sum_in = sum_ff + 32'(yaw_ac);
         end else begin
            ticks_in = '0;
            sum_in = '0;
         end
         if (ticks_in >= STEADY_FULL) begin
            acoff_in = acoff_ff - 16'(sum_in >>> STEADY_LOG2);
            ticks_in = '0;
            sum_in = '0;
         end
      end
      if (cmd.curve) prod_in = 32'(mul_p >>> CURVE_SHIFT);
      if (cmd.gain) begin
         if (mul_p < -50'sd32768) t = -16'sd32768;
         else if (mul_p > 50'sd32767) t = 16'sd32767;
         else t = mul_p[15:0];
         res_in[cmd.axis] = valid_ff ? t : '0;
      end
      // Hand the finished item to the output registers.
      if (cmd.emit) begin
         ovld_in = valid_ff;
         ores_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b1;
         cnt_ff <= '0;
         ready_ff <= 1'b0;
         ticks_ff <= '0;
         prev_ff <= '0;
         sum_ff <= '0;
         acoff_ff <= '0;
         valid_ff <= 1'b0;
         ovld_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= '0;
            bias_ff[i] <= '0;
            ores_ff[i] <= '0;
         end
      end else begin
         pending_ff <= pending_in;
         cnt_ff <= cnt_in;
         ready_ff <= ready_in;
         ticks_ff <= ticks_in;
         prev_ff <= prev_in;
         sum_ff <= sum_in;
         acoff_ff <= acoff_in;
         valid_ff <= valid_in;
         ovld_ff <= ovld_in;
         off_ff <= off_in;
         bias_ff <= bias_in;
         ores_ff <= ores_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
      rec_ff <= rec_in;
      prod_ff <= prod_in;
      res_ff <= res_in;
   end

   assign status.ready = ready_ff;
   assign valid_out = ovld_ff;
   assign yaw_out = ores_ff[0];
   assign roll_out = ores_ff[1];
   assign pitch_out = ores_ff[2];

endmodule

@@ hw/rtl/hac_controller.sv @@
// ----------------------------------------------------------------------------
// hac_controller
// Sequencer that steps one item through the datapath and holds the result.
// ----------------------------------------------------------------------------
module hac_controller
   import hac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

`include "head_angle_conditioner_assert.svh"

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       ovalid_ff, ovalid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      cmd = '0;
      cmd.axis = axis_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            cmd.center = 1'b1;
            state_in = ST_DRIFT_MUL;
         end
         ST_DRIFT_MUL: begin
            cmd.drift_mul = 1'b1;
            state_in = ST_DRIFT_SUB;
         end
         ST_DRIFT_SUB: begin
            if (status.ready) cmd.drift_sub = 1'b1;
            state_in = ST_AUTO;
         end
         ST_AUTO: begin
            if (status.ready) cmd.auto_step = 1'b1;
            axis_in = '0;
            state_in = ST_CURVE;
         end
         ST_CURVE: begin
            cmd.curve = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            if (axis_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               axis_in = axis_ff + 2'd1;
               state_in = ST_CURVE;
            end
         end
         ST_OUT: begin
            if (!ovalid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               ovalid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = ovalid_ff;

   `HAC_ASSERT(a_accept_idle, (req_valid && req_ready) |=> (state_ff == ST_CENTER),
               "accepted item did not start processing")
   `HAC_ASSERT(a_axis_range, (axis_ff != 2'd3), "axis counter out of range")
   `HAC_ASSERT(a_out_hold, (rsp_valid && !rsp_ready) |=> rsp_valid,
               "result dropped while stalled")
   `HAC_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid),
               "reset did not clear controller")

endmodule

@@ hw/rtl/head_angle_conditioner.sv @@
// ----------------------------------------------------------------------------
// head_angle_conditioner
// Centers, drift-corrects, auto-centers and scales head tracker angles.
// ----------------------------------------------------------------------------
// A sequencer steps each accepted item through centering, a drift multiply,
// auto-centering and one curve and gain multiply per axis, all on one shared
// multiplier, and takes no new item until the last one is in the output
// register. The result sits in that register, so the next item is taken while
// it waits to be read.
module head_angle_conditioner
   import hac_pkg::*;
#(
   parameter int CENTER_SAMPLES_LOG2 = 3,
   parameter int STEADY_SAMPLES_LOG2 = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic               req_recenter_request,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_angles_valid,
   output logic signed [15:0] rsp_out_yaw,
   output logic signed [15:0] rsp_out_roll,
   output logic signed [15:0] rsp_out_pitch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic signed [15:0] drift_ff, gain_y_ff, gain_r_ff, gain_p_ff;
   logic               linear_ff;
   logic [6:0]         level_ff;
   logic [2:0]         ridx;
   cmd_type            cmd;
   status_type         status;

   assign pready = 1'b1;
   assign ridx = paddr[4:2];

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff <= '0;
         linear_ff <= 1'b1;
         gain_y_ff <= 16'sd1;
         gain_r_ff <= 16'sd1;
         gain_p_ff <= 16'sd1;
         level_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (ridx)
            REG_DRIFT:  drift_ff <= pwdata[15:0];
            REG_LINEAR: linear_ff <= pwdata[0];
            REG_GAIN_Y: gain_y_ff <= pwdata[15:0];
            REG_GAIN_R: gain_r_ff <= pwdata[15:0];
            REG_GAIN_P: gain_p_ff <= pwdata[15:0];
            REG_LEVEL:  level_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (ridx)
         REG_DRIFT:  prdata = 32'(unsigned'(drift_ff));
         REG_LINEAR: prdata = 32'(linear_ff);
         REG_GAIN_Y: prdata = 32'(unsigned'(gain_y_ff));
         REG_GAIN_R: prdata = 32'(unsigned'(gain_r_ff));
         REG_GAIN_P: prdata = 32'(unsigned'(gain_p_ff));
         REG_LEVEL:  prdata = 32'(level_ff);
         default:    prdata = '0;
      endcase
   end

   hac_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hac_datapath #(
      .CENTER_LOG2 (CENTER_SAMPLES_LOG2),
      .STEADY_LOG2 (STEADY_SAMPLES_LOG2)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .yaw_in      (req_yaw_angle),
      .roll_in     (req_roll_angle),
      .pitch_in    (req_pitch_angle),
      .recenter_in (req_recenter_request),
      .drift       (drift_ff),
      .linear      (linear_ff),
      .gain_y      (gain_y_ff),
      .gain_r      (gain_r_ff),
      .gain_p      (gain_p_ff),
      .level       (level_ff),
      .valid_out   (rsp_angles_valid),
      .yaw_out     (rsp_out_yaw),
      .roll_out    (rsp_out_roll),
      .pitch_out   (rsp_out_pitch)
   );

endmodule

@@ dv/head_angle_conditioner_checker.sv @@
// ----------------------------------------------------------------------------
// head_angle_conditioner_checker
// Tracks the register writes and predicts the result of every accepted item
// from its own copy of the conditioner state. Each result the block returns
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module head_angle_conditioner_checker
   import hac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic               req_recenter_request,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_angles_valid,
   input  logic signed [15:0] rsp_out_yaw,
   input  logic signed [15:0] rsp_out_roll,
   input  logic signed [15:0] rsp_out_pitch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 fails,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               valid;
      logic signed [15:0] yaw;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
   } angles_type;

   // Register copy.
   logic signed [15:0] drift;
   logic               linear;
   logic signed [15:0] gain [3];
   logic [6:0]         level;

   // Conditioner state copy.
   logic               recenter_pending;
   logic [31:0]        sample_count;
   logic signed [15:0] center [3];
   logic signed [15:0] bias [3];
   logic               centered;
   int                 steady_ticks;
   logic signed [15:0] prev_yaw;
   logic signed [31:0] steady_sum;
   logic signed [15:0] auto_offset;

   angles_type expected_angles [$];

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Advances the state copy by one item and returns the conditioned angles.
   function automatic angles_type condition(logic signed [15:0] yaw,
                                            logic signed [15:0] roll,
                                            logic signed [15:0] pitch,
                                            logic recenter);
      logic signed [15:0] e [3];
      logic signed [15:0] window;
      logic signed [15:0] t16;
      logic signed [31:0] p32;
      longint             prod;
      longint             v;
      int                 lim;
      angles_type         r;
      e[0] = yaw;
      e[1] = roll;
      e[2] = pitch;
      r = '0;
      if (recenter) recenter_pending = 1'b1;
      if (recenter_pending) begin
         sample_count = 32'hFFFF_FFF8;
         recenter_pending = 1'b0;
         centered = 1'b0;
         for (int i = 0; i < 3; i++) begin
            bias[i] = e[i];
            center[i] = '0;
         end
      end
      sample_count = sample_count + 1;
      if (!centered)
         for (int i = 0; i < 3; i++) center[i] = center[i] + e[i] - bias[i];
      if (sample_count == 0) begin
         for (int i = 0; i < 3; i++) center[i] = (center[i] >>> 3) + bias[i];
         centered = 1'b1;
      end
      if (!centered) return r;

      for (int i = 0; i < 3; i++) e[i] = e[i] - center[i];

      // Drift grows with the sample count.
      prod = longint'($signed(sample_count)) * longint'(drift);
      p32 = prod[31:0];
      t16 = 16'(p32 >>> 10);
      e[0] = e[0] - t16;

      // Auto-centering after a run of steady samples near straight ahead.
      if (level != 0) begin
         lim = int'(level) * 300;
         window = lim[15:0];
         if (sample_count == 0) auto_offset = '0;
         e[0] = e[0] + auto_offset;
         if (mag(e[0]) < longint'(window) && mag(longint'(e[0]) - prev_yaw) < 300
             && mag(e[2]) < 1000) begin
            steady_ticks++;
            steady_sum = steady_sum + e[0];
         end else begin
            steady_ticks = 0;
            steady_sum = '0;
         end
         prev_yaw = e[0];
         if (steady_ticks >= 64) begin
            t16 = 16'(steady_sum >>> 6);
            auto_offset = auto_offset - t16;
            steady_ticks = 0;
            steady_sum = '0;
         end
      end

      // Response curve and saturating gains.
      for (int i = 0; i < 3; i++) begin
         v = e[i];
         if (!linear) begin
            prod = (v * mag(v)) >>> 13;
            t16 = prod[15:0];
            v = t16;
         end
         prod = v * longint'(gain[i]);
         if (prod < -32768) prod = -32768;
         else if (prod > 32767) prod = 32767;
         e[i] = prod[15:0];
      end
      r.valid = 1'b1;
      r.yaw = e[0];
      r.roll = e[1];
      r.pitch = e[2];
      return r;
   endfunction

   always @(posedge clock) begin
      angles_type got;
      angles_type want;
      if (reset) begin
         drift <= '0;
         linear <= 1'b1;
         gain <= '{16'sd1, 16'sd1, 16'sd1};
         level <= '0;
         recenter_pending = 1'b1;
         sample_count = '0;
         center = '{3{16'sd0}};
         bias = '{3{16'sd0}};
         centered = 1'b0;
         steady_ticks = 0;
         prev_yaw = '0;
         steady_sum = '0;
         auto_offset = '0;
         expected_angles.delete();
         fails <= 0;
         outstanding <= 0;
      end else begin
         // Register writes.
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_DRIFT:  drift <= pwdata[15:0];
               REG_LINEAR: linear <= pwdata[0];
               REG_GAIN_Y: gain[0] <= pwdata[15:0];
               REG_GAIN_R: gain[1] <= pwdata[15:0];
               REG_GAIN_P: gain[2] <= pwdata[15:0];
               REG_LEVEL:  level <= pwdata[6:0];
               default: ;
            endcase
         end
         // Accepted item.
         if (req_valid && req_ready)
            expected_angles.push_back(condition(req_yaw_angle, req_roll_angle,
                                                req_pitch_angle, req_recenter_request));
         // Returned result.
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_angles_valid, rsp_out_yaw, rsp_out_roll, rsp_out_pitch};
            if (expected_angles.size() == 0) begin
               $error("result returned with no item outstanding");
               fails <= fails + 1;
            end else begin
               want = expected_angles.pop_front();
               if (got != want) begin
                  if (got.valid != want.valid)
                     $error("angles_valid: expected %0d, got %0d", want.valid, got.valid);
                  if (got.yaw != want.yaw)
                     $error("out_yaw: expected %0d, got %0d", want.yaw, got.yaw);
                  if (got.roll != want.roll)
                     $error("out_roll: expected %0d, got %0d", want.roll, got.roll);
                  if (got.pitch != want.pitch)
                     $error("out_pitch: expected %0d, got %0d", want.pitch, got.pitch);
                  fails <= fails + 1;
               end
            end
         end
         outstanding <= expected_angles.size();
      end
   end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the head angle conditioner: register settings in phases,
// directed extreme angles, steady near-ahead runs that reach auto-centering,
// and full-range noise, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
   import hac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_yaw_angle = '0;
   logic signed [15:0] req_roll_angle = '0;
   logic signed [15:0] req_pitch_angle = '0;
   logic               req_recenter_request = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_angles_valid;
   logic signed [15:0] rsp_out_yaw;
   logic signed [15:0] rsp_out_roll;
   logic signed [15:0] rsp_out_pitch;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   int  fails;
   int  outstanding;
   int  cycles = 0;
   int  items_sent;
   bit  no_idle = 1'b0;
   int  stall_left = 0;

   head_angle_conditioner u_dut (.*);
   head_angle_conditioner_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: a random stall, which may be none, after each result taken.
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         draw = no_idle ? 0 : $urandom_range(0, 6);
         stall_left <= draw;
         rsp_ready <= (draw == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(int drift, bit linear, int gy, int gr, int gp, int level);
      write_reg(REG_DRIFT, 32'(drift));
      write_reg(REG_LINEAR, 32'(linear));
      write_reg(REG_GAIN_Y, 32'(gy));
      write_reg(REG_GAIN_R, 32'(gr));
      write_reg(REG_GAIN_P, 32'(gp));
      write_reg(REG_LEVEL, 32'(level));
   endtask

   // Holds the sender until every outstanding item has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send_angles(int yaw, int roll, int pitch, bit recenter);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_yaw_angle <= 16'(yaw);
      req_roll_angle <= 16'(roll);
      req_pitch_angle <= 16'(pitch);
      req_recenter_request <= recenter;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
   endtask

   // A steady run around a random heading with small jitter, which may open with a recenter request.
   task automatic steady_run(int count, int jitter);
      int base_yaw;
      int base_pitch;
      base_yaw = $urandom_range(0, 65535) - 32768;
      base_pitch = $urandom_range(0, 1200) - 600;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++)
         send_angles(base_yaw + $urandom_range(0, 2 * jitter) - jitter,
                     $urandom_range(0, 65535) - 32768,
                     base_pitch + $urandom_range(0, 2 * jitter) - jitter,
                     i == 0 && $urandom_range(0, 1));
      no_idle = 1'b0;
   endtask

   task automatic noise(int count);
      for (int i = 0; i < count; i++)
         send_angles($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                     $urandom_range(0, 65535) - 32768, $urandom_range(0, 7) == 0);
   endtask

   task automatic random_phase(int count, int jitter);
      int start;
      start = items_sent;
      while (items_sent - start < count) begin
         if ($urandom_range(0, 9) < 7) steady_run(80, jitter);
         else noise($urandom_range(3, 12));
      end
   endtask

   initial begin
      items_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: square law on, centering after reset, then extremes.
      configure(0, 1'b0, 1, 1, 1, 109);
      for (int i = 0; i < 8; i++) send_angles(32767, -32768, 0, 1'b0);
      send_angles(-32768, 32767, -32768, 1'b0);
      send_angles(32767, -32768, 32767, 1'b0);
      send_angles(0, 0, 0, 1'b0);
      send_angles(-1, 1, -1, 1'b1);
      for (int i = 0; i < 7; i++) send_angles(-1 + i, 1, 999, 1'b0);
      send_angles(-32768, -32768, -32768, 1'b0);
      send_angles(32767, 32767, 32767, 1'b0);
      drain();

      // Drift extreme with saturating gains.
      configure(32767, 1'b0, 32767, -32768, 7, 109);
      send_angles(100, -100, 50, 1'b1);
      noise(20);
      drain();

      configure(0, 1'b1, 1, 1, 1, 20);
      random_phase(60, 40);
      // Sender pause until every result is back, mid-stream.
      drain();
      random_phase(50, 40);
      drain();

      configure(-32768, 1'b0, -32768, 32767, -1, 0);
      random_phase(80, 200);
      drain();

      configure(5, 1'b1, 300, -3, 128, 1);
      random_phase(80, 100);
      drain();

      configure(0, 1'b0, 1, 1, 1, 50);
      random_phase(80, 60);
      drain();

      repeat (20) @(posedge clock);
      if (fails == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
